### rtl/flash_block_mapper_wear_level_assert.svh
// Assertion macros used by the flash block mapper checker.
`ifndef FLASH_BLOCK_MAPPER_WEAR_LEVEL_ASSERT_SVH
`define FLASH_BLOCK_MAPPER_WEAR_LEVEL_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define FBMWL_AST_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbmwl check failed");

// Check the consequent in the cycle after the antecedent.
`define FBMWL_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbmwl check failed");

`endif

### rtl/fbmwl_pkg.sv
// Shared types and constants of the flash block mapper.
package fbmwl_pkg;

    localparam int LB_W      = 5;
    localparam int LOGICAL   = 32;
    localparam int THR_W     = 16;
    localparam int SEC_W     = 5;
    localparam int ST_W      = 2;
    localparam int OP_W      = 3;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = ST_W + OP_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd5;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_ZERO  = 3'd3;
    localparam logic [OP_W-1:0] OP_COPY  = 3'd4;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_MAPRD  = 9'b000000100,
        S_ER_WR  = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_REMAP  = 9'b001000000,
        S_WIPE   = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OP_W-1:0]  op;
        logic [SEC_W-1:0] sector;
        logic [SEC_W-1:0] src;
        logic             last;
    } t_cmd;

endpackage

### rtl/flash_block_mapper_wear_level.sv
// Top level of the flash block mapper with wear leveling.
//
//  channel   direction  signals                            item
//  s side    in         i_s_tvalid/o_s_tready/tdata/tuser  request: kind, logical block
//  m side    out        o_m_tvalid/i_m_tready/tdata/tuser  disk command, tlast on final one
//  config    in         i_cfg_wr_en/i_cfg_wr_data          wear threshold write
//
// Sequence: a read or erase is served after the map read; a write scans the
// block memory sequentially through its read port, and when it swaps with a
// cold block it scans the map memory as well.
// Reset: synchronous, active low; afterwards a clearing pass sweeps every
// block of the block memory (writable, count zero) while no request is taken.
// Stalls: one output register holds a command; the sequencer holds in any
// state that issues a command until that register is free.
module flash_block_mapper_wear_level
    import fbmwl_pkg::*;
#(
    parameter int BLOCKS      = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [THR_W-1:0]     i_cfg_wr_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [4:0] logical_block
    input  logic [KIND_W-1:0]    i_s_tuser,   // [1:0] kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [4:0] sector, [9:5] source_sector
    output logic [M_TUSER_W-1:0] o_m_tuser,   // [1:0] status, [4:2] op
    output logic                 o_m_tlast    // last
);

    localparam int PW   = $clog2(BLOCKS);
    localparam int CW   = COUNT_WIDTH;
    localparam int CMPW = (CW > THR_W) ? CW : THR_W;
    localparam logic [PW-1:0]   BLK_LAST = PW'(BLOCKS - 1);
    localparam logic [LB_W-1:0] LB_LAST  = LB_W'(LOGICAL - 1);

    // Saturating erase count increment.
    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == {CW{1'b1}}) ? c : c + CW'(1);
    endfunction

    // Sequencer state and scan counters.
    t_state          r_state, n_state;
    logic [PW-1:0]   r_idx, n_idx;
    logic            r_iss_done, n_iss_done;
    logic            r_pend;
    logic [PW-1:0]   r_pidx;
    logic [LB_W-1:0] r_lidx, n_lidx;
    logic            r_lpend;
    logic [LB_W-1:0] r_plidx;
    logic            r_found, n_found;
    logic            blk_issue, map_issue;

    // Request being served and configuration.
    logic [KIND_W-1:0]  r_kind;
    logic [LB_W-1:0]    r_lb;
    logic [THR_W-1:0]   r_thr;
    logic [LOGICAL-1:0] r_map_vld, n_map_vld;
    logic               accept;

    // Logical map memory: physical index per logical block.
    logic [PW-1:0]   r_map_mem [LOGICAL];
    logic [PW-1:0]   r_map_q;
    logic            map_rd_en, map_wr_en;
    logic [LB_W-1:0] map_rd_addr, map_wr_addr;
    logic [PW-1:0]   map_wr_data;

    // Block memory: {writable, erase count} per physical block.
    logic [CW:0]   r_blk_mem [BLOCKS];
    logic [CW:0]   r_blk_q;
    logic          blk_rd_en, blk_wr_en;
    logic [PW-1:0] blk_rd_addr, blk_wr_addr;
    logic [CW:0]   blk_wr_data;

    // Output register.
    logic r_m_tvalid;
    t_cmd r_cmd, cmd;
    logic emit, out_free, load;

    // Least-count results.
    logic          have_w, have_c, swap;
    logic [PW-1:0] best_w, best_c;
    logic [CW-1:0] w_cnt, c_cnt;
    logic          scan_clr;

    fbmwl_scan #(
        .PW (PW),
        .CW (CW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (scan_clr),
        .i_vld    (r_pend),
        .i_idx    (r_pidx),
        .i_wr     (r_blk_q[CW]),
        .i_cnt    (r_blk_q[CW-1:0]),
        .o_have_w (have_w),
        .o_best_w (best_w),
        .o_w_cnt  (w_cnt),
        .o_have_c (have_c),
        .o_best_c (best_c),
        .o_c_cnt  (c_cnt)
    );

    assign out_free = !r_m_tvalid || i_m_tready;
    assign load     = emit && out_free;
    assign accept   = i_s_tvalid && (r_state == S_IDLE);
    // swap when a cold block exists and the least-worn writable block has reached the threshold
    assign swap     = have_c && (CMPW'(w_cnt) >= CMPW'(r_thr));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_iss_done  = r_iss_done;
        n_lidx      = r_lidx;
        n_found     = r_found;
        n_map_vld   = r_map_vld;
        blk_issue   = 1'b0;
        map_issue   = 1'b0;
        map_rd_en   = 1'b0;
        map_rd_addr = i_s_tdata[LB_W-1:0];
        map_wr_en   = 1'b0;
        map_wr_addr = r_lb;
        map_wr_data = best_w;
        blk_rd_en   = 1'b0;
        blk_rd_addr = r_idx;
        blk_wr_en   = 1'b0;
        blk_wr_addr = r_idx;
        blk_wr_data = {1'b1, {CW{1'b0}}};
        emit        = 1'b0;
        cmd         = '0;
        scan_clr    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // sweep every block to writable with count zero
                blk_wr_en = 1'b1;
                if (r_idx == BLK_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    map_rd_en = 1'b1;
                    n_state   = S_MAPRD;
                end
            end
            S_MAPRD: begin
                scan_clr = 1'b1;
                case (r_kind)
                    KIND_READ: begin
                        emit = 1'b1;
                        if (r_map_vld[r_lb]) begin
                            cmd.status = ST_OK;
                            cmd.op     = OP_READ;
                            cmd.sector = SEC_W'(r_map_q);
                        end else begin
                            cmd.status = ST_UNMAPPED;
                        end
                        cmd.last = 1'b1;
                        if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    KIND_WRITE: begin
                        if (r_map_vld[r_lb]) begin
                            blk_rd_en   = 1'b1;
                            blk_rd_addr = r_map_q;
                            n_state     = S_ER_WR;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    KIND_ERASE: begin
                        if (r_map_vld[r_lb]) begin
                            blk_rd_en   = 1'b1;
                            blk_rd_addr = r_map_q;
                            n_state     = S_ER_WR;
                        end else begin
                            emit     = 1'b1;
                            cmd.last = 1'b1;
                            if (out_free) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    default: begin
                        // unknown request: one empty command
                        emit     = 1'b1;
                        cmd.last = 1'b1;
                        if (out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_ER_WR: begin
                // zero-fill the old block, count it, free it, drop the mapping
                emit       = 1'b1;
                cmd.op     = OP_ZERO;
                cmd.sector = SEC_W'(r_map_q);
                cmd.last   = (r_kind == KIND_ERASE);
                if (out_free) begin
                    blk_wr_en   = 1'b1;
                    blk_wr_addr = r_map_q;
                    blk_wr_data = {1'b1, sat_inc(r_blk_q[CW-1:0])};
                    n_map_vld[r_lb] = 1'b0;
                    n_state = (r_kind == KIND_ERASE) ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN: begin
                // one block read a cycle; the tracker sees each one in the cycle after its read
                if (!r_iss_done) begin
                    blk_rd_en = 1'b1;
                    blk_issue = 1'b1;
                    if (r_idx == BLK_LAST) begin
                        n_idx      = '0;
                        n_iss_done = 1'b1;
                    end else begin
                        n_idx = r_idx + PW'(1);
                    end
                end
                if (r_pend && (r_pidx == BLK_LAST)) begin
                    n_iss_done = 1'b0;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                emit = 1'b1;
                if (!have_w) begin
                    cmd.status = ST_NOSPACE;
                    cmd.last   = 1'b1;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (swap) begin
                    // copy the cold block into the least-worn one
                    cmd.op     = OP_COPY;
                    cmd.sector = SEC_W'(best_w);
                    cmd.src    = SEC_W'(best_c);
                    if (out_free) begin
                        blk_wr_en   = 1'b1;
                        blk_wr_addr = best_w;
                        blk_wr_data = {1'b0, w_cnt};
                        n_found     = 1'b0;
                        n_state     = S_REMAP;
                    end
                end else begin
                    cmd.op     = OP_WRITE;
                    cmd.sector = SEC_W'(best_w);
                    cmd.last   = 1'b1;
                    if (out_free) begin
                        blk_wr_en   = 1'b1;
                        blk_wr_addr = best_w;
                        blk_wr_data = {1'b0, w_cnt};
                        map_wr_en   = 1'b1;
                        n_map_vld[r_lb] = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_REMAP: begin
                // move the cold block's owner, if any, to the copy
                if (!r_iss_done) begin
                    map_rd_en   = 1'b1;
                    map_rd_addr = r_lidx;
                    map_issue   = 1'b1;
                    if (r_lidx == LB_LAST) begin
                        n_lidx     = '0;
                        n_iss_done = 1'b1;
                    end else begin
                        n_lidx = r_lidx + LB_W'(1);
                    end
                end
                if (r_lpend && !r_found && r_map_vld[r_plidx] && (r_map_q == best_c)) begin
                    map_wr_en   = 1'b1;
                    map_wr_addr = r_plidx;
                    n_found     = 1'b1;
                end
                if (r_lpend && (r_plidx == LB_LAST)) begin
                    n_iss_done = 1'b0;
                    n_state    = S_WIPE;
                end
            end
            S_WIPE: begin
                // erase the cold block; it takes the host data next
                emit       = 1'b1;
                cmd.op     = OP_ZERO;
                cmd.sector = SEC_W'(best_c);
                if (out_free) begin
                    blk_wr_en   = 1'b1;
                    blk_wr_addr = best_c;
                    blk_wr_data = {1'b0, sat_inc(c_cnt)};
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                emit       = 1'b1;
                cmd.op     = OP_WRITE;
                cmd.sector = SEC_W'(best_c);
                cmd.last   = 1'b1;
                if (out_free) begin
                    map_wr_en   = 1'b1;
                    map_wr_data = best_c;
                    n_map_vld[r_lb] = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_iss_done <= 1'b0;
            r_pend     <= 1'b0;
            r_lidx     <= '0;
            r_lpend    <= 1'b0;
            r_found    <= 1'b0;
            r_map_vld  <= '0;
            r_thr      <= THR_RESET;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_iss_done <= n_iss_done;
            r_pend     <= blk_issue;
            r_lidx     <= n_lidx;
            r_lpend    <= map_issue;
            r_found    <= n_found;
            r_map_vld  <= n_map_vld;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pidx  <= r_idx;
        r_plidx <= r_lidx;
        if (accept) begin
            r_kind <= i_s_tuser;
            r_lb   <= i_s_tdata[LB_W-1:0];
        end
        if (load) begin
            r_cmd <= cmd;
        end
    end

    // Map memory, one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (map_wr_en) begin
            r_map_mem[map_wr_addr] <= map_wr_data;
        end
        if (map_rd_en) begin
            r_map_q <= r_map_mem[map_rd_addr];
        end
    end

    // Block memory, one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (blk_wr_en) begin
            r_blk_mem[blk_wr_addr] <= blk_wr_data;
        end
        if (blk_rd_en) begin
            r_blk_q <= r_blk_mem[blk_rd_addr];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(M_TDATA_W - 2 * SEC_W){1'b0}}, r_cmd.src, r_cmd.sector};
    assign o_m_tuser  = {r_cmd.op, r_cmd.status};
    assign o_m_tlast  = r_cmd.last;

endmodule

### rtl/fbmwl_scan.sv
// Running least-count tracker for writable and cold physical blocks.
module fbmwl_scan #(
    parameter int PW = 5,
    parameter int CW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_vld,
    input  logic [PW-1:0] i_idx,
    input  logic          i_wr,
    input  logic [CW-1:0] i_cnt,
    output logic          o_have_w,
    output logic [PW-1:0] o_best_w,
    output logic [CW-1:0] o_w_cnt,
    output logic          o_have_c,
    output logic [PW-1:0] o_best_c,
    output logic [CW-1:0] o_c_cnt
);

    logic          r_have_w, r_have_c;
    logic [PW-1:0] r_best_w, r_best_c;
    logic [CW-1:0] r_w_cnt, r_c_cnt;
    logic          take_w, take_c;

    // strict compare in ascending index order keeps the lowest index on ties
    assign take_w = i_vld && i_wr && (!r_have_w || (i_cnt < r_w_cnt));
    assign take_c = i_vld && !i_wr && (!r_have_c || (i_cnt < r_c_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_w <= 1'b0;
            r_have_c <= 1'b0;
        end else if (i_clr) begin
            r_have_w <= 1'b0;
            r_have_c <= 1'b0;
        end else begin
            if (take_w) begin
                r_have_w <= 1'b1;
            end
            if (take_c) begin
                r_have_c <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_w) begin
            r_best_w <= i_idx;
            r_w_cnt  <= i_cnt;
        end
        if (take_c) begin
            r_best_c <= i_idx;
            r_c_cnt  <= i_cnt;
        end
    end

    assign o_have_w = r_have_w;
    assign o_best_w = r_best_w;
    assign o_w_cnt  = r_w_cnt;
    assign o_have_c = r_have_c;
    assign o_best_c = r_best_c;
    assign o_c_cnt  = r_c_cnt;

endmodule

### rtl/fbmwl_chk.sv
// Port checker of the flash block mapper and its bind to the top level.
`include "flash_block_mapper_wear_level_assert.svh"

module fbmwl_chk
    import fbmwl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 i_s_tready,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] i_m_tdata,
    input logic [M_TUSER_W-1:0] i_m_tuser,
    input logic                 i_m_tlast
);

    logic [ST_W-1:0] status;
    logic [OP_W-1:0] op;
    logic            s_acc;

    assign status = i_m_tuser[ST_W-1:0];
    assign op     = i_m_tuser[ST_W +: OP_W];
    assign s_acc  = i_s_tvalid && i_s_tready;

    // a stalled command holds
    `FBMWL_AST_NEXT(a_m_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))
    // error statuses carry no command and end the run
    `FBMWL_AST_NOW(a_err_last, i_clk, i_rst_n, i_m_tvalid && (status != ST_OK), (op == OP_NONE) && i_m_tlast)
    // a copy never carries tlast, since the cold block erase and the write follow it
    `FBMWL_AST_NOW(a_copy_mid, i_clk, i_rst_n, i_m_tvalid && (op == OP_COPY), !i_m_tlast)
    `FBMWL_AST_NOW(a_op_code, i_clk, i_rst_n, i_m_tvalid, (op == OP_NONE) || (op == OP_READ) || (op == OP_WRITE) || (op == OP_ZERO) || (op == OP_COPY))
    // a request in work blocks the next one
    `FBMWL_AST_NEXT(a_one_req, i_clk, i_rst_n, s_acc, !i_s_tready)

endmodule

bind flash_block_mapper_wear_level fbmwl_chk u_fbmwl_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);
